// ===== rtl/s1h_pkg.sv =====
// Shared types, constants and round helpers for the SHA-1 stream hasher.
// Used by s1h_core, sha1_stream_hasher and tb_top; depends on nothing else.
`timescale 1ns / 1ps
`default_nettype none

package s1h_pkg;

  // Number of words in one message block, and rounds per block.
  localparam int unsigned BLOCK_WORDS = 16;
  localparam int unsigned ROUNDS      = 80;

  // Chaining value after reset and after every digest.
  localparam logic [31:0] IV0 = 32'h6745_2301;
  localparam logic [31:0] IV1 = 32'hEFCD_AB89;
  localparam logic [31:0] IV2 = 32'h98BA_DCFE;
  localparam logic [31:0] IV3 = 32'h1032_5476;
  localparam logic [31:0] IV4 = 32'hC3D2_E1F0;

  // Round constants, one per group of twenty rounds.
  localparam logic [31:0] K0 = 32'h5A82_7999;
  localparam logic [31:0] K1 = 32'h6ED9_EBA1;
  localparam logic [31:0] K2 = 32'h8F1B_BCDC;
  localparam logic [31:0] K3 = 32'hCA62_C1D6;

  // Word that carries the padding byte alone.
  localparam logic [31:0] PAD_WORD = 32'h8000_0000;

  // One input transaction.
  typedef struct packed {
    logic [31:0] message_word;
    logic [2:0]  valid_bytes;
    logic        last_word;
  } s1h_in_t;

  // One result transaction: the five digest words.
  typedef struct packed {
    logic [31:0] digest_h0;
    logic [31:0] digest_h1;
    logic [31:0] digest_h2;
    logic [31:0] digest_h3;
    logic [31:0] digest_h4;
  } s1h_out_t;

  // Commands from the padding sequencer to the compression core.
  typedef struct packed {
    logic load;       // shift one word into the block
    logic load_last;  // this word completes the block: start the rounds
    logic init;       // return the chaining value to its initial value
  } s1h_ctl_t;

  // Round function for the group that holds round number rnd.
  function automatic logic [31:0] round_fn(input logic [6:0] rnd, input logic [31:0] b,
                                           input logic [31:0] c, input logic [31:0] d);
    logic [31:0] res;
    if (rnd < 7'd20) begin
      res = (b & c) | (~b & d);
    end else if (rnd < 7'd40) begin
      res = b ^ c ^ d;
    end else if (rnd < 7'd60) begin
      res = (b & c) | (b & d) | (c & d);
    end else begin
      res = b ^ c ^ d;
    end
    return res;
  endfunction

  // Round constant for round number rnd.
  function automatic logic [31:0] round_k(input logic [6:0] rnd);
    logic [31:0] res;
    if (rnd < 7'd20) begin
      res = K0;
    end else if (rnd < 7'd40) begin
      res = K1;
    end else if (rnd < 7'd60) begin
      res = K2;
    end else begin
      res = K3;
    end
    return res;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/s1h_core.sv =====
// SHA-1 compression core: block shift register, one round per cycle, chaining value.
// Depends on s1h_pkg.
`timescale 1ns / 1ps
`default_nettype none

module s1h_core (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire s1h_pkg::s1h_ctl_t ctl,
  input  wire logic [31:0]     load_word,
  output logic                 busy,
  output s1h_pkg::s1h_out_t    chain
);
  import s1h_pkg::*;

  localparam logic [6:0] LAST_ROUND = 7'(ROUNDS - 1);
  localparam logic [6:0] FOLD_STEP  = 7'(ROUNDS);

  logic [31:0] w_r [BLOCK_WORDS];
  logic [31:0] a_r, b_r, c_r, d_r, e_r;
  logic [31:0] h0_r, h1_r, h2_r, h3_r, h4_r;
  logic [6:0]  round_r, round_nxt;
  logic        busy_r, busy_nxt;
  logic        rounding;
  logic [31:0] t_word;
  logic [31:0] w_expand;

  // A round runs while busy and the counter has not reached the fold step.
  assign rounding = busy_r && (round_r != FOLD_STEP);

  // Shared round adder and the next schedule word.
  assign t_word   = {a_r[26:0], a_r[31:27]} + round_fn(round_r, b_r, c_r, d_r)
                    + e_r + round_k(round_r) + w_r[0];
  assign w_expand = {w_r[13][30:0] ^ w_r[8][30:0] ^ w_r[2][30:0] ^ w_r[0][30:0],
                     w_r[13][31] ^ w_r[8][31] ^ w_r[2][31] ^ w_r[0][31]};

  // Sequencer: start on the word that fills a block, stop after the fold step.
  always_comb begin
    busy_nxt  = busy_r;
    round_nxt = round_r;
    if (ctl.load_last) begin
      busy_nxt  = 1'b1;
      round_nxt = '0;
    end else if (rounding) begin
      round_nxt = round_r + 7'd1;
    end else if (busy_r) begin
      busy_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r  <= 1'b0;
      round_r <= '0;
    end else begin
      busy_r  <= busy_nxt;
      round_r <= round_nxt;
    end
  end

  // Block words: shifted in while loading, expanded in place while rounding.
  always_ff @(posedge clk) begin
    if (ctl.load || rounding) begin
      for (int i = 0; i < BLOCK_WORDS - 1; i++) begin
        w_r[i] <= w_r[i + 1];
      end
      w_r[BLOCK_WORDS - 1] <= ctl.load ? load_word : w_expand;
    end
  end

  // Working variables: loaded from the chain at block start, one round per cycle.
  always_ff @(posedge clk) begin
    if (ctl.load_last) begin
      a_r <= h0_r;
      b_r <= h1_r;
      c_r <= h2_r;
      d_r <= h3_r;
      e_r <= h4_r;
    end else if (rounding) begin
      a_r <= t_word;
      b_r <= a_r;
      c_r <= {b_r[1:0], b_r[31:2]};
      d_r <= c_r;
      e_r <= d_r;
    end
  end

  // Chaining value: folded after the last round, restored after a digest.
  always_ff @(posedge clk) begin
    if (!rst_n || ctl.init) begin
      h0_r <= IV0;
      h1_r <= IV1;
      h2_r <= IV2;
      h3_r <= IV3;
      h4_r <= IV4;
    end else if (busy_r && !rounding) begin
      h0_r <= h0_r + a_r;
      h1_r <= h1_r + b_r;
      h2_r <= h2_r + c_r;
      h3_r <= h3_r + d_r;
      h4_r <= h4_r + e_r;
    end
  end

  assign busy  = busy_r;
  assign chain = '{digest_h0: h0_r, digest_h1: h1_r, digest_h2: h2_r,
                   digest_h3: h3_r, digest_h4: h4_r};

  // The round counter never runs past the fold step.
  a_round_range: assert property (@(posedge clk) disable iff (!rst_n)
    round_r <= FOLD_STEP)
    else $error("round counter out of range");

  // After the last round comes the fold step.
  a_fold_follows: assert property (@(posedge clk) disable iff (!rst_n)
    (busy_r && round_r == LAST_ROUND && !ctl.load_last) |=> (busy_r && round_r == FOLD_STEP))
    else $error("fold step missed");

  // No block word is loaded while the rounds run.
  a_no_load_busy: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r |-> !ctl.load)
    else $error("word loaded during compression");

endmodule

`default_nettype wire

// ===== rtl/sha1_stream_hasher.sv =====
// Top level of the streaming SHA-1 hasher: input framing, padding and digest output.
// Depends on s1h_pkg and s1h_core.
`timescale 1ns / 1ps
`default_nettype none

// Message words enter one per cycle until a 16-word block is full; the block is
// then compressed by a single shared round unit (the rounds, then a fold into the
// chaining value), during which in_stall is high. The word marked last is
// followed by the padding words (a 0x80 word when the last word was full, zero
// fill and the two length words) and one or two compressions, after which the
// digest lands in the output register and the next message may begin at once. A
// new message's words are taken while an earlier digest still waits on out_stall.
module sha1_stream_hasher (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire s1h_pkg::s1h_in_t  in_data,
  output logic                   out_valid,
  input  wire logic              out_stall,
  output s1h_pkg::s1h_out_t      out_data
);
  import s1h_pkg::*;

  // Sequencer states.
  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_PAD    = 2'd1;
  localparam logic [1:0] ST_LEN_LO = 2'd2;
  localparam logic [1:0] ST_FIN    = 2'd3;

  logic [1:0]  state_r, state_nxt;
  logic [3:0]  fill_r, fill_nxt;
  logic [63:0] bitlen_r, bitlen_nxt;
  logic        pend80_r, pend80_nxt;
  logic        out_valid_r, out_valid_nxt;
  s1h_out_t    out_data_r;
  logic        capture;
  logic        in_acc;
  logic [2:0]  nbytes;
  logic [31:0] last_word_data;
  s1h_ctl_t    ctl;
  logic [31:0] push_data;
  logic        core_busy;
  s1h_out_t    chain;

  s1h_core u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctl       (ctl),
    .load_word (push_data),
    .busy      (core_busy),
    .chain     (chain)
  );

  assign in_stall = (state_r != ST_IDLE) || core_busy;
  assign in_acc   = in_valid && !in_stall;

  // Byte count, with counts above four taken as four.
  assign nbytes = in_data.valid_bytes[2] ? 3'd4 : in_data.valid_bytes;

  // Final data word: keep the valid leading bytes and place the padding byte.
  always_comb begin
    unique case (nbytes)
      3'd0:    last_word_data = PAD_WORD;
      3'd1:    last_word_data = {in_data.message_word[31:24], 24'h80_0000};
      3'd2:    last_word_data = {in_data.message_word[31:16], 16'h8000};
      3'd3:    last_word_data = {in_data.message_word[31:8], 8'h80};
      default: last_word_data = in_data.message_word;
    endcase
  end

  // Padding sequencer: pick the word pushed into the block this cycle.
  always_comb begin
    state_nxt     = state_r;
    fill_nxt      = fill_r;
    bitlen_nxt    = bitlen_r;
    pend80_nxt    = pend80_r;
    ctl           = '0;
    push_data     = '0;
    capture       = 1'b0;
    out_valid_nxt = out_valid_r && out_stall;
    unique case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          ctl.load = 1'b1;
          if (in_data.last_word) begin
            push_data  = last_word_data;
            bitlen_nxt = bitlen_r + {58'd0, nbytes, 3'd0};
            pend80_nxt = (nbytes == 3'd4);
            state_nxt  = ST_PAD;
          end else begin
            push_data  = in_data.message_word;
            bitlen_nxt = bitlen_r + 64'd32;
          end
        end
      end
      ST_PAD: begin
        if (!core_busy) begin
          ctl.load = 1'b1;
          if (pend80_r) begin
            push_data  = PAD_WORD;
            pend80_nxt = 1'b0;
          end else if (fill_r != 4'd14) begin
            push_data = '0;
          end else begin
            push_data = bitlen_r[63:32];
            state_nxt = ST_LEN_LO;
          end
        end
      end
      ST_LEN_LO: begin
        ctl.load  = 1'b1;
        push_data = bitlen_r[31:0];
        state_nxt = ST_FIN;
      end
      ST_FIN: begin
        if (!core_busy && !(out_valid_r && out_stall)) begin
          capture       = 1'b1;
          ctl.init      = 1'b1;
          out_valid_nxt = 1'b1;
          bitlen_nxt    = '0;
          state_nxt     = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
    // Every loaded word advances the fill count; the sixteenth starts a block.
    if (ctl.load) begin
      fill_nxt      = fill_r + 4'd1;
      ctl.load_last = (fill_r == 4'(BLOCK_WORDS - 1));
    end
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      fill_r      <= '0;
      bitlen_r    <= '0;
      pend80_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      fill_r      <= fill_nxt;
      bitlen_r    <= bitlen_nxt;
      pend80_r    <= pend80_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Digest output register.
  always_ff @(posedge clk) begin
    if (capture) begin
      out_data_r <= chain;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // A digest is only taken from an idle core with a free output register.
  a_capture_safe: assert property (@(posedge clk) disable iff (!rst_n)
    capture |-> (!core_busy && !(out_valid_r && out_stall)))
    else $error("digest captured while busy or output blocked");

  // A new digest always leaves the block empty and the length cleared.
  a_clean_after: assert property (@(posedge clk) disable iff (!rst_n)
    capture |=> (fill_r == 4'd0 && bitlen_r == 64'd0 && state_r == ST_IDLE))
    else $error("state not cleared after digest");

  // A digest only appears after the final block of a message.
  a_rose_from_fin: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r) == ST_FIN)
    else $error("digest without final block");

endmodule

`default_nettype wire

// ===== dv/tb_top.sv =====
// Self-checking testbench for sha1_stream_hasher: directed messages, then random ones.
// Depends on s1h_pkg and the RTL of sha1_stream_hasher; digests come from a local SHA-1 model or the table.
`timescale 1ns / 1ps

module tb_top;
  import s1h_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 600000;
  localparam int unsigned DRAIN_CYCLES = 400;
  localparam int unsigned PHASE_WORDS = 350;
  localparam int unsigned DIR_ROWS = 11;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  s1h_in_t in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  s1h_out_t out_data;

  // Percentages of cycles in which the sender idles and the receiver stalls.
  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;

  int unsigned fail_count = 0;
  int unsigned cycle_count = 0;
  int unsigned words_sent = 0;
  int unsigned messages_sent = 0;
  int unsigned digests_seen = 0;

  // Digests still owed by the block, oldest first.
  s1h_out_t digest_queue[$];

  // Local copy of the hash state.
  logic [31:0] hash_chain[5];
  logic [31:0] hash_block[16];
  int unsigned hash_fill;
  logic [63:0] hash_bits;

  // One row of the directed stimulus: a word repeated reps times, with an optional
  // known digest that is checked instead of the computed one.
  typedef struct {
    s1h_in_t     item;
    int unsigned reps;
    bit          known;
    s1h_out_t    digest;
  } dir_row_t;

  dir_row_t dir_table[DIR_ROWS] = '{
    // Empty message: only padding.
    '{'{32'h0000_0000, 3'd0, 1'b1}, 1, 1'b1,
      '{32'hDA39_A3EE, 32'h5E6B_4B0D, 32'h3255_BFEF, 32'h9560_1890, 32'hAFD8_0709}},
    // "abc" with a nonzero byte past the valid ones, which must be ignored.
    '{'{32'h6162_63FF, 3'd3, 1'b1}, 1, 1'b1,
      '{32'hA999_3E36, 32'h4706_816A, 32'hBA3E_2571, 32'h7850_C26C, 32'h9CD0_D89D}},
    // Count above four on a last word.
    '{'{32'hFFFF_FFFF, 3'd7, 1'b1}, 1, 1'b0, '0},
    // Short counts on words that are not last still carry four bytes.
    '{'{32'hFFFF_FFFF, 3'd0, 1'b0}, 1, 1'b0, '0},
    '{'{32'h0000_0000, 3'd6, 1'b0}, 1, 1'b0, '0},
    '{'{32'h8000_0001, 3'd1, 1'b1}, 1, 1'b0, '0},
    // Full last word: the padding byte opens the next word.
    '{'{32'h1234_5678, 3'd4, 1'b1}, 1, 1'b0, '0},
    // 56 bytes: the length no longer fits, so a second final block follows.
    '{'{32'hFFFF_FFFF, 3'd4, 1'b0}, 13, 1'b0, '0},
    '{'{32'hFFFF_FFFF, 3'd4, 1'b1}, 1, 1'b0, '0},
    '{'{32'hA5A5_A5A5, 3'd5, 1'b0}, 1, 1'b0, '0},
    '{'{32'h5A5A_5A5A, 3'd2, 1'b1}, 1, 1'b0, '0}
  };

  sha1_stream_hasher dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data)
  );

  // 2 ns clock.
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  function automatic logic [31:0] rotl(input logic [31:0] x, input int unsigned n);
    return (x << n) | (x >> (32 - n));
  endfunction

  // Start a new message from the initial chaining value.
  function automatic void hash_restart();
    hash_chain[0] = IV0;
    hash_chain[1] = IV1;
    hash_chain[2] = IV2;
    hash_chain[3] = IV3;
    hash_chain[4] = IV4;
    hash_fill = 0;
    hash_bits = '0;
  endfunction

  // Eighty rounds over the current block, folded into the chaining value.
  function automatic void hash_compress();
    logic [31:0] sched[80];
    logic [31:0] a, b, c, d, e, f, k, t;
    for (int r = 0; r < 80; r++) begin
      if (r < 16) begin
        sched[r] = hash_block[r];
      end else begin
        sched[r] = rotl(sched[r-3] ^ sched[r-8] ^ sched[r-14] ^ sched[r-16], 1);
      end
    end
    a = hash_chain[0];
    b = hash_chain[1];
    c = hash_chain[2];
    d = hash_chain[3];
    e = hash_chain[4];
    for (int r = 0; r < 80; r++) begin
      if (r < 20) begin
        f = (b & c) | (~b & d);
        k = K0;
      end else if (r < 40) begin
        f = b ^ c ^ d;
        k = K1;
      end else if (r < 60) begin
        f = (b & c) | (b & d) | (c & d);
        k = K2;
      end else begin
        f = b ^ c ^ d;
        k = K3;
      end
      t = rotl(a, 5) + f + e + k + sched[r];
      e = d;
      d = c;
      c = rotl(b, 30);
      b = a;
      a = t;
    end
    hash_chain[0] += a;
    hash_chain[1] += b;
    hash_chain[2] += c;
    hash_chain[3] += d;
    hash_chain[4] += e;
  endfunction

  function automatic void hash_push(input logic [31:0] w);
    hash_block[hash_fill] = w;
    hash_fill++;
    if (hash_fill == 16) begin
      hash_compress();
      hash_fill = 0;
    end
  endfunction

  // Absorb one input transaction; returns 1 with the digest when the word is last.
  function automatic bit hash_absorb(input s1h_in_t item, output s1h_out_t digest);
    int unsigned nbytes;
    logic [31:0] keep;
    digest = '0;
    nbytes = (item.valid_bytes > 3'd4) ? 4 : item.valid_bytes;
    if (!item.last_word) begin
      hash_push(item.message_word);
      hash_bits += 64'd32;
      return 1'b0;
    end
    hash_bits += 64'(nbytes * 8);
    if (nbytes == 4) begin
      hash_push(item.message_word);
      hash_push(PAD_WORD);
    end else begin
      keep = (nbytes == 0) ? 32'h0 : (32'hFFFF_FFFF << (8 * (4 - nbytes)));
      hash_push((item.message_word & keep) | (32'h80 << (8 * (3 - nbytes))));
    end
    // With no room left for the length, zero-fill and compress an extra block.
    if (hash_fill > 14) begin
      while (hash_fill != 0) hash_push(32'h0);
    end
    while (hash_fill < 14) hash_push(32'h0);
    hash_push(hash_bits[63:32]);
    hash_push(hash_bits[31:0]);
    digest = '{hash_chain[0], hash_chain[1], hash_chain[2], hash_chain[3], hash_chain[4]};
    hash_restart();
    return 1'b1;
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("MISMATCH %s: got %08h, expected %08h (cycle %0d)", what, got, want, cycle_count);
    fail_count++;
  endtask

  // Offer one transaction, wait for the block to take it, then update the model.
  task automatic send_word(input s1h_in_t item, input bit known, input s1h_out_t known_digest);
    s1h_out_t digest;
    while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= item;
    do @(posedge clk); while (in_stall);
    words_sent++;
    if (hash_absorb(item, digest)) begin
      messages_sent++;
      digest_queue.push_back(known ? known_digest : digest);
    end
  endtask

  function automatic logic [31:0] pick_word();
    logic [31:0] w;
    case ($urandom_range(9))
      0: w = 32'h0000_0000;
      1: w = 32'hFFFF_FFFF;
      default: w = $urandom;
    endcase
    return w;
  endfunction

  // One random message: mostly full words, now and then an odd count on a middle word.
  task automatic send_message();
    int unsigned len;
    s1h_in_t item;
    case ($urandom_range(9))
      0, 1, 2, 3, 4, 5: len = $urandom_range(12, 0);
      6, 7, 8: len = $urandom_range(17, 13);
      default: len = $urandom_range(48, 18);
    endcase
    for (int unsigned i = 0; i < len; i++) begin
      item.message_word = pick_word();
      item.valid_bytes = ($urandom_range(9) < 8) ? 3'd4 : 3'($urandom_range(7));
      item.last_word = 1'b0;
      send_word(item, 1'b0, '0);
    end
    item.message_word = pick_word();
    item.valid_bytes = 3'($urandom_range(7));
    item.last_word = 1'b1;
    send_word(item, 1'b0, '0);
  endtask

  task automatic run_phase(input int unsigned idle_pct, input int unsigned stall_pct);
    int unsigned start;
    send_idle_pct = idle_pct;
    recv_stall_pct = stall_pct;
    start = words_sent;
    while (words_sent - start < PHASE_WORDS) send_message();
  endtask

  // Receiver: random stalls, and each accepted digest is checked against the oldest one owed.
  always @(posedge clk) begin
    s1h_out_t want;
    if (rst_n && out_valid && !out_stall) begin
      digests_seen++;
      if (digest_queue.size() == 0) begin
        report_mismatch("digest with none outstanding, h0", out_data.digest_h0, 32'h0);
      end else begin
        want = digest_queue.pop_front();
        if (out_data.digest_h0 !== want.digest_h0)
          report_mismatch("digest_h0", out_data.digest_h0, want.digest_h0);
        if (out_data.digest_h1 !== want.digest_h1)
          report_mismatch("digest_h1", out_data.digest_h1, want.digest_h1);
        if (out_data.digest_h2 !== want.digest_h2)
          report_mismatch("digest_h2", out_data.digest_h2, want.digest_h2);
        if (out_data.digest_h3 !== want.digest_h3)
          report_mismatch("digest_h3", out_data.digest_h3, want.digest_h3);
        if (out_data.digest_h4 !== want.digest_h4)
          report_mismatch("digest_h4", out_data.digest_h4, want.digest_h4);
      end
    end
    out_stall <= (recv_stall_pct != 0) && ($urandom_range(99) < recv_stall_pct);
  end

  // Watchdog on the whole run.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles with %0d digests outstanding",
               cycle_count, digest_queue.size());
      $display("Simulation FAILED");
      $finish;
    end
  end

  // Main sequence: reset, directed table, three random phases, drain.
  initial begin
    int unsigned dir_words;
    hash_restart();
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_idle_pct = 8;
    recv_stall_pct = 73;
    for (int i = 0; i < DIR_ROWS; i++) begin
      for (int unsigned j = 0; j < dir_table[i].reps; j++) begin
        send_word(dir_table[i].item, dir_table[i].known, dir_table[i].digest);
      end
    end
    dir_words = words_sent;

    run_phase(8, 73);
    run_phase(73, 8);
    run_phase(0, 0);
    in_valid <= 1'b0;

    while (digest_queue.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Hashed %0d messages from %0d words (%0d directed) under three idle patterns.",
             messages_sent, words_sent, dir_words);
    $display("Compared %0d digests, %0d mismatches, %0d cycles.",
             digests_seen, fail_count, cycle_count);
    if (fail_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/s1h_pkg.sv
rtl/s1h_core.sv
rtl/sha1_stream_hasher.sv
dv/tb_top.sv
